/* rtl/orq_pkg.sv */
// Shared constants, mode codes and index helpers for the overwrite ring queue.
package orq_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CAP_W  = 7;
	localparam int WORD_W = 32;
	localparam int CNT_W  = 6;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_PEEK   = 2'd1;
	localparam logic [1:0] MODE_POP    = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CAP_W-1:0] cap_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [WORD_W-1:0] word_t;

	// next slot in a ring of cap slots
	function automatic idx_t ring_next(input idx_t idx, input cap_t cap);
		cap_t n;
		n = CAP_W'(idx) + CAP_W'(1);
		return (n >= cap) ? '0 : idx_t'(n);
	endfunction

	// number of words between head and tail
	function automatic cap_t ring_count(input idx_t head, input idx_t tail, input cap_t cap);
		cap_t h;
		cap_t t;
		h = CAP_W'(head);
		t = CAP_W'(tail);
		return (t >= h) ? (t - h) : (t + cap - h);
	endfunction

endpackage

/* rtl/orq_if.sv */
// Valid/ready channels for request and result beats.
interface orq_item_if import orq_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic signed [31:0] data_in;
	logic [CNT_W-1:0]  count_requested;

	modport source (output valid, mode, data_in, count_requested, input ready);
	modport sink   (input valid, mode, data_in, count_requested, output ready);
endinterface

interface orq_result_if import orq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [31:0] data_out;
	logic               has_data;
	logic               last;
	logic [CNT_W-1:0]   count_taken;
	logic               dropped_oldest;
	logic               queue_full;
	logic               queue_empty;

	modport source (output valid, data_out, has_data, last, count_taken, dropped_oldest,
		queue_full, queue_empty, input ready);
	modport sink   (input valid, data_out, has_data, last, count_taken, dropped_oldest,
		queue_full, queue_empty, output ready);
endinterface

/* rtl/overwrite_ring_queue.sv */
// Overwrite ring queue: top level with pointer control, read sequencer and result register.
// Insert, status-only peek/pop and unused mode: one status beat each, result registered next cycle.
// Peek/pop of n words: the accept starts the sequencer, which issues the read; each word passes the
// RAM read register and then the result register, at one word per cycle while the result is
// taken; input closed until the last word is loaded. The word RAM read port sets that rate.
// Reset: head and tail at zero, capacity 64, queue empty; word RAM contents undefined.
module overwrite_ring_queue import orq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CAP_W-1:0]    cfg_wdata,
	orq_item_if.sink            item,
	orq_result_if.source        result
);
	// pointer and configuration state
	cap_t  cap_q;
	idx_t  head_q;
	idx_t  tail_q;

	// read sequencer
	logic  busy_q;
	idx_t  rd_idx_q;
	cnt_t  left_q;
	cnt_t  taken_q;
	logic  full_after_q;
	logic  empty_after_q;
	logic  rd_pend_s1;
	logic  last_s1;

	// result register
	logic  out_v_q;
	word_t out_data_q;
	logic  out_has_q;
	logic  out_last_q;
	cnt_t  out_taken_q;
	logic  out_drop_q;
	logic  out_full_q;
	logic  out_empty_q;

	logic  accept;
	logic  start_rd;
	logic  status_beat;
	logic  out_free;
	logic  load_word;
	logic  issue;
	word_t ram_rdata;
	logic  ram_we;

	// insert path
	logic  ins_full;
	idx_t  ins_head;
	idx_t  ins_tail;

	// peek/pop path
	cap_t  stored;
	cnt_t  take_n;
	cap_t  pop_sum;
	idx_t  pop_head;
	logic  pk_full;
	logic  pk_empty;
	logic  pop_full;
	logic  pop_empty;
	cap_t  cfg_clamped;

	assign out_free    = !out_v_q || result.ready;
	assign item.ready  = !busy_q && out_free;
	assign accept      = item.valid && item.ready;

	// peek/pop with words to return starts a read sequence; everything else is one status beat
	assign start_rd    = accept && (item.mode == MODE_PEEK || item.mode == MODE_POP)
		&& (take_n != '0);
	assign status_beat = accept && !start_rd;

	// a word leaves the read register when the result slot frees up
	assign load_word   = rd_pend_s1 && out_free;
	// next read only when the read register is empty or being drained this cycle
	assign issue       = busy_q && (left_q != '0) && (!rd_pend_s1 || load_word);

	assign ram_we      = accept && (item.mode == MODE_INSERT);

	// insert: drop the head first when full
	always_comb begin
		ins_full = (head_q == ring_next(tail_q, cap_q));
		ins_head = ins_full ? ring_next(head_q, cap_q) : head_q;
		ins_tail = ring_next(tail_q, cap_q);
	end

	// clamp the request to what is stored; pop head moves past the taken words
	always_comb begin
		stored    = ring_count(head_q, tail_q, cap_q);
		take_n    = (CAP_W'(item.count_requested) < stored) ? item.count_requested
			: cnt_t'(stored);
		pop_sum   = CAP_W'(head_q) + CAP_W'(take_n);
		pop_head  = (pop_sum >= cap_q) ? idx_t'(pop_sum - cap_q) : idx_t'(pop_sum);
		pk_full   = (head_q == ring_next(tail_q, cap_q));
		pk_empty  = (head_q == tail_q);
		pop_full  = (pop_head == ring_next(tail_q, cap_q));
		pop_empty = (pop_head == tail_q);
	end

	always_comb begin
		cfg_clamped = cfg_wdata;
		if (cfg_wdata < CAP_W'(2)) begin
			cfg_clamped = CAP_W'(2);
		end else if (cfg_wdata > CAP_W'(DEPTH)) begin
			cfg_clamped = CAP_W'(DEPTH);
		end
	end

	orq_ram #(
		.ADDR_W (IDX_W),
		.DATA_W (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (word_t'(item.data_in)),
		.re    (issue),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// pointers and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_W'(DEPTH);
			head_q <= '0;
			tail_q <= '0;
		end else if (cfg_we) begin
			cap_q  <= cfg_clamped;
			head_q <= '0;
			tail_q <= '0;
		end else if (accept) begin
			if (item.mode == MODE_INSERT) begin
				head_q <= ins_head;
				tail_q <= ins_tail;
			end else if (item.mode == MODE_POP) begin
				head_q <= pop_head;
			end
		end
	end

	// read sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			left_q     <= '0;
			rd_pend_s1 <= 1'b0;
			last_s1    <= 1'b0;
		end else begin
			if (start_rd) begin
				busy_q <= 1'b1;
				left_q <= take_n;
			end else if (issue) begin
				left_q <= left_q - cnt_t'(1);
			end
			if (load_word && last_s1) begin
				busy_q <= 1'b0;
			end
			if (issue) begin
				rd_pend_s1 <= 1'b1;
				last_s1    <= (left_q == cnt_t'(1));
			end else if (load_word) begin
				rd_pend_s1 <= 1'b0;
			end
		end
	end

	// sequencer payload: read pointer, clamped count and flags after the step
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_idx_q      <= head_q;
			taken_q       <= take_n;
			full_after_q  <= (item.mode == MODE_POP) ? pop_full : pk_full;
			empty_after_q <= (item.mode == MODE_POP) ? pop_empty : pk_empty;
		end else if (issue) begin
			rd_idx_q <= ring_next(rd_idx_q, cap_q);
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_word || status_beat) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// result register payload; status_beat and load_word never coincide (busy interlock)
	always_ff @(posedge clk) begin
		if (load_word) begin
			out_data_q  <= ram_rdata;
			out_has_q   <= 1'b1;
			out_last_q  <= last_s1;
			out_taken_q <= taken_q;
			out_drop_q  <= 1'b0;
			out_full_q  <= full_after_q;
			out_empty_q <= empty_after_q;
		end else if (status_beat) begin
			out_data_q  <= '0;
			out_has_q   <= 1'b0;
			out_last_q  <= 1'b1;
			case (item.mode)
				MODE_INSERT: begin
					out_taken_q <= cnt_t'(1);
					out_drop_q  <= ins_full;
					out_full_q  <= (ins_head == ring_next(ins_tail, cap_q));
					out_empty_q <= (ins_head == ins_tail);
				end
				MODE_PEEK, MODE_POP: begin
					// only reached here with nothing to return
					out_taken_q <= '0;
					out_drop_q  <= 1'b0;
					out_full_q  <= pk_full;
					out_empty_q <= pk_empty;
				end
				default: begin
					out_taken_q <= '0;
					out_drop_q  <= 1'b0;
					out_full_q  <= pk_full;
					out_empty_q <= pk_empty;
				end
			endcase
		end
	end

	assign result.valid          = out_v_q;
	assign result.data_out       = $signed(out_data_q);
	assign result.has_data       = out_has_q;
	assign result.last           = out_last_q;
	assign result.count_taken    = out_taken_q;
	assign result.dropped_oldest = out_drop_q;
	assign result.queue_full     = out_full_q;
	assign result.queue_empty    = out_empty_q;

	// no new request while a peek/pop is still streaming
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !busy_q)
		else $error("request taken while streaming");

	// RAM is never written under an outstanding read sequence
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !busy_q && !rd_pend_s1)
		else $error("write during read sequence");

	// pointers stay inside the ring
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CAP_W'(head_q) < cap_q) && (CAP_W'(tail_q) < cap_q))
		else $error("pointer beyond capacity");

	// read data only pending inside a sequence
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> busy_q)
		else $error("stray pending read");

	// a sequence ends by loading its final word
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> out_v_q && out_last_q && out_has_q)
		else $error("sequence ended without final word");
endmodule

/* rtl/orq_ram.sv */
// Simple dual-port RAM, registered read that holds while not enabled.
module orq_ram #(
	parameter int ADDR_W = 6,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
